### rtl/core/hsvsb_pkg.sv
// Package for the HSV saturation boost unit: constants, reciprocals and the
// hue sector type. No dependencies.
`default_nettype none

package hsvsb_pkg;

   localparam int          GAIN_FRAC_BITS_DEF = 4;
   localparam int          GAIN_W             = 8;
   localparam int          PIX_W              = 8;
   localparam logic [7:0]  SAT_GAIN_RESET     = 8'd24;

   // hue degrees/2 per sector
   localparam logic [7:0]  HUE_SECTOR         = 8'd30;
   // 255*30, the ramp channel denominator
   localparam logic [12:0] RAMP_DEN           = 13'd7650;
   localparam logic [7:0]  FULL_SCALE         = 8'd255;

   // floor(2^24/255) and floor(2^32/7650); quotients come out at most one low
   localparam logic [16:0] RECIP_255          = 17'd65793;
   localparam logic [19:0] RECIP_7650         = 20'd561433;

   typedef enum logic [2:0] {
      SEC_0 = 3'd0,
      SEC_1 = 3'd1,
      SEC_2 = 3'd2,
      SEC_3 = 3'd3,
      SEC_4 = 3'd4,
      SEC_5 = 3'd5
   } sector_type;

endpackage

`default_nettype wire

### rtl/core/hsv_saturation_boost_unit.sv
// HSV saturation boost unit: BGR pixel to HSV, saturation gain, back to BGR.
// Depends on hsvsb_pkg.
//
//  channel | ports                                  | direction
//  --------+----------------------------------------+-----------
//  request | req_valid/req_stall, req_*_in          | in
//  result  | rsp_valid/rsp_stall, rsp_*_out         | out
//  csr     | csr_valid/csr_ready, csr_sat_gain      | in
//
// Fifteen register stages; one pixel enters per clock while the result side does not stall.
// The two bit-serial dividers (saturation and hue), one quotient bit per
// stage over eight stages, set the depth.
// Synchronous reset clears the valid bits and loads the gain with 24.
// A stall on the result side fills empty stages first, then holds the pipe.
`default_nettype none

module hsv_saturation_boost_unit #(
   parameter int GAIN_FRAC_BITS = hsvsb_pkg::GAIN_FRAC_BITS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic [7:0] req_blue_in,
   input  wire logic [7:0] req_green_in,
   input  wire logic [7:0] req_red_in,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic [7:0] rsp_blue_out,
   output      logic [7:0] rsp_green_out,
   output      logic [7:0] rsp_red_out,
   input  wire logic       csr_valid,
   output      logic       csr_ready,
   input  wire logic [7:0] csr_sat_gain
);
   import hsvsb_pkg::*;

   localparam int NSTG = 15;
   localparam int NDIV = 8;

   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] en;
   logic [7:0]      gain_ff;

   // pipeline enables: a stage loads when empty or when its successor loads
   always_comb begin
      en[NSTG-1] = !vld_ff[NSTG-1] || !rsp_stall;
      for (int k = NSTG-2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = vld_ff[NSTG-1];
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         gain_ff <= SAT_GAIN_RESET;
      end else begin
         if (csr_valid) begin
            gain_ff <= csr_sat_gain;
         end
         if (en[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int k = 1; k < NSTG; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // stage 0: input register
   logic [7:0] r0_ff, g0_ff, b0_ff;
   always_ff @(posedge clock) begin
      if (en[0]) begin
         r0_ff <= req_red_in;
         g0_ff <= req_green_in;
         b0_ff <= req_blue_in;
      end
   end

   // stage 1: max, min, delta, saturation and hue numerators
   logic [7:0]  mx, mn, dl;
   logic [15:0] hnum, snum;
   logic [15:0] d30, d60, d120, d180;

   always_comb begin
      mx = r0_ff;
      mn = r0_ff;
      if (g0_ff > mx) mx = g0_ff;
      if (b0_ff > mx) mx = b0_ff;
      if (g0_ff < mn) mn = g0_ff;
      if (b0_ff < mn) mn = b0_ff;
      dl   = mx - mn;
      d30  = 16'(dl) * 16'd30;
      d60  = {d30[14:0], 1'b0};
      d120 = {d30[13:0], 2'b0};
      d180 = d120 + d60;
      snum = (16'(dl) << 8) - 16'(dl);
      if (mx == r0_ff) begin
         if (g0_ff >= b0_ff) hnum = 16'(g0_ff - b0_ff) * 16'd30;
         else                hnum = d180 - 16'(b0_ff - g0_ff) * 16'd30;
      end else if (mx == g0_ff) begin
         if (b0_ff >= r0_ff) hnum = d60 + 16'(b0_ff - r0_ff) * 16'd30;
         else                hnum = d60 - 16'(r0_ff - b0_ff) * 16'd30;
      end else begin
         if (r0_ff >= g0_ff) hnum = d120 + 16'(r0_ff - g0_ff) * 16'd30;
         else                hnum = d120 - 16'(g0_ff - r0_ff) * 16'd30;
      end
   end

   // divider pipeline: entry 0 is stage 1, entry j is stage 1+j
   logic [7:0]  dv_ff [NDIV+1];
   logic [7:0]  dd_ff [NDIV+1];
   logic [15:0] rs_ff [NDIV+1];
   logic [15:0] rh_ff [NDIV+1];
   logic [7:0]  qs_ff [NDIV+1];
   logic [7:0]  qh_ff [NDIV+1];

   always_ff @(posedge clock) begin
      if (en[1]) begin
         dv_ff[0] <= mx;
         dd_ff[0] <= dl;
         rs_ff[0] <= snum;
         rh_ff[0] <= hnum;
         qs_ff[0] <= '0;
         qh_ff[0] <= '0;
      end
   end

   for (genvar j = 1; j <= NDIV; j++) begin : g_div
      localparam int SH = NDIV - j;
      logic [16:0] sdiv, hdiv;
      logic        sge, hge;
      assign sdiv = 17'(dv_ff[j-1]) << SH;
      assign hdiv = 17'(dd_ff[j-1]) << SH;
      assign sge  = {1'b0, rs_ff[j-1]} >= sdiv;
      assign hge  = {1'b0, rh_ff[j-1]} >= hdiv;
      always_ff @(posedge clock) begin
         if (en[1+j]) begin
            dv_ff[j] <= dv_ff[j-1];
            dd_ff[j] <= dd_ff[j-1];
            rs_ff[j] <= sge ? 16'({1'b0, rs_ff[j-1]} - sdiv) : rs_ff[j-1];
            rh_ff[j] <= hge ? 16'({1'b0, rh_ff[j-1]} - hdiv) : rh_ff[j-1];
            qs_ff[j] <= {qs_ff[j-1][6:0], sge};
            qh_ff[j] <= {qh_ff[j-1][6:0], hge};
         end
      end
   end

   // stage 10: gain and hue sector
   logic [7:0]  s_a, h_a, f_a, ss_a;
   logic [15:0] sprod, sshift;
   sector_type  sec_a;
   logic [4:0]  t_a;

   always_comb begin
      s_a    = (dv_ff[NDIV] == '0) ? '0 : qs_ff[NDIV];
      h_a    = (dd_ff[NDIV] == '0) ? '0 : qh_ff[NDIV];
      sprod  = 16'(s_a) * 16'(gain_ff);
      sshift = sprod >> GAIN_FRAC_BITS;
      ss_a   = (|sshift[15:8]) ? FULL_SCALE : sshift[7:0];
      if (h_a >= 8'(5 * HUE_SECTOR)) begin
         sec_a = SEC_5;
         f_a   = h_a - 8'(5 * HUE_SECTOR);
      end else if (h_a >= 8'(4 * HUE_SECTOR)) begin
         sec_a = SEC_4;
         f_a   = h_a - 8'(4 * HUE_SECTOR);
      end else if (h_a >= 8'(3 * HUE_SECTOR)) begin
         sec_a = SEC_3;
         f_a   = h_a - 8'(3 * HUE_SECTOR);
      end else if (h_a >= 8'(2 * HUE_SECTOR)) begin
         sec_a = SEC_2;
         f_a   = h_a - 8'(2 * HUE_SECTOR);
      end else if (h_a >= HUE_SECTOR) begin
         sec_a = SEC_1;
         f_a   = h_a - HUE_SECTOR;
      end else begin
         sec_a = SEC_0;
         f_a   = h_a;
      end
      // odd sectors ramp downwards
      t_a = sec_a[0] ? 5'(HUE_SECTOR - f_a) : f_a[4:0];
   end

   logic [7:0] sa_ff, va_ff;
   logic [4:0] ta_ff;
   sector_type seca_ff;
   always_ff @(posedge clock) begin
      if (en[10]) begin
         sa_ff   <= ss_a;
         va_ff   <= dv_ff[NDIV];
         ta_ff   <= t_a;
         seca_ff <= sec_a;
      end
   end

   // stage 11: ramp factor and zero-channel product
   logic [13:0] mb;
   always_comb begin
      mb = 14'(RAMP_DEN) + 14'(sa_ff) * 14'(ta_ff) - 14'(sa_ff) * 14'd30;
   end

   logic [12:0] mb_ff;
   logic [15:0] zxb_ff;
   logic [7:0]  vb_ff;
   sector_type  secb_ff;
   always_ff @(posedge clock) begin
      if (en[11]) begin
         mb_ff   <= mb[12:0];
         zxb_ff  <= 16'(va_ff) * 16'(FULL_SCALE - sa_ff);
         vb_ff   <= va_ff;
         secb_ff <= seca_ff;
      end
   end

   // stage 12: ramp product and zero-channel reciprocal estimate
   logic [32:0] zprod;
   assign zprod = 33'(zxb_ff) * 33'(RECIP_255);

   logic [20:0] rxc_ff;
   logic [15:0] zxc_ff;
   logic [7:0]  zqc_ff, vc_ff;
   sector_type  secc_ff;
   always_ff @(posedge clock) begin
      if (en[12]) begin
         rxc_ff  <= 21'(vb_ff) * 21'(mb_ff);
         zxc_ff  <= zxb_ff;
         zqc_ff  <= zprod[31:24];
         vc_ff   <= vb_ff;
         secc_ff <= secb_ff;
      end
   end

   // stage 13: correct zero channel, estimate ramp channel
   logic [40:0] rprod;
   logic [16:0] zrem;
   logic [7:0]  zero_d;
   assign rprod  = 41'(rxc_ff) * 41'(RECIP_7650);
   assign zrem   = {1'b0, zxc_ff} - (17'({zqc_ff, 8'b0}) - 17'(zqc_ff));
   assign zero_d = (zrem >= 17'(FULL_SCALE)) ? zqc_ff + 8'd1 : zqc_ff;

   logic [20:0] rxd_ff;
   logic [7:0]  rqd_ff, zrd_ff, vd_ff;
   sector_type  secd_ff;
   always_ff @(posedge clock) begin
      if (en[13]) begin
         rxd_ff  <= rxc_ff;
         rqd_ff  <= rprod[39:32];
         zrd_ff  <= zero_d;
         vd_ff   <= vc_ff;
         secd_ff <= secc_ff;
      end
   end

   // stage 14: correct ramp channel, route channels by sector
   logic [20:0] rrem;
   logic [7:0]  ramp_e, ro, go, bo;
   always_comb begin
      rrem   = rxd_ff - 21'(rqd_ff) * 21'(RAMP_DEN);
      ramp_e = (rrem >= 21'(RAMP_DEN)) ? rqd_ff + 8'd1 : rqd_ff;
      case (secd_ff)
         SEC_0: begin
            ro = vd_ff;  go = ramp_e; bo = zrd_ff;
         end
         SEC_1: begin
            ro = ramp_e; go = vd_ff;  bo = zrd_ff;
         end
         SEC_2: begin
            ro = zrd_ff; go = vd_ff;  bo = ramp_e;
         end
         SEC_3: begin
            ro = zrd_ff; go = ramp_e; bo = vd_ff;
         end
         SEC_4: begin
            ro = ramp_e; go = zrd_ff; bo = vd_ff;
         end
         default: begin
            ro = vd_ff;  go = zrd_ff; bo = ramp_e;
         end
      endcase
   end

   logic [7:0] ro_ff, go_ff, bo_ff;
   always_ff @(posedge clock) begin
      if (en[14]) begin
         ro_ff <= ro;
         go_ff <= go;
         bo_ff <= bo;
      end
   end

   assign rsp_red_out   = ro_ff;
   assign rsp_green_out = go_ff;
   assign rsp_blue_out  = bo_ff;

   // a held result stays valid
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result lost under stall");

   // input is only held off behind an occupied first stage
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> vld_ff[0])
      else $error("request stalled with empty first stage");

   // hue quotient stays below 180 for a coloured pixel
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[9] && (dd_ff[NDIV] != '0) |-> qh_ff[NDIV] < 8'd180)
      else $error("hue out of range");

   // corrected zero channel never exceeds the value channel
   a_zero_le_v: assert property (@(posedge clock) disable iff (reset)
      vld_ff[13] |-> zrd_ff <= vd_ff)
      else $error("zero channel above value");

endmodule

`default_nettype wire

### sim/tb.sv
// Self-checking testbench for hsv_saturation_boost_unit: random BGR pixels,
// gain settings and handshake gaps, checked against a behavioural predictor.
// Depends on hsvsb_pkg and the unit RTL.
`default_nettype none

class pixel_scoreboard;
   logic [23:0] pending_pixels[$];
   int          mismatch_count;
   int          orphan_count;
   logic [7:0]  gain;

   function new();
      mismatch_count = 0;
      orphan_count   = 0;
      gain           = hsvsb_pkg::SAT_GAIN_RESET;
   endfunction

   // predict {blue, green, red} for one pixel at the current gain
   function logic [23:0] boost_pixel(logic [7:0] b_in, logic [7:0] g_in, logic [7:0] r_in);
      int unsigned b, g, r;
      int unsigned mx, mn, d, num, h, s, v, t, f, full_c, zero_c, ramp_c;
      int unsigned ro, go, bo;
      hsvsb_pkg::sector_type sec;
      b = 32'(b_in); g = 32'(g_in); r = 32'(r_in);
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d = mx - mn;
      v = mx;
      s = (mx == 0) ? 0 : (255 * d) / mx;
      if (d == 0) begin
         h = 0;
      end else begin
         if (mx == r) begin
            num = (g >= b) ? 30 * (g - b) : 180 * d - 30 * (b - g);
         end else if (mx == g) begin
            num = (b >= r) ? 60 * d + 30 * (b - r) : 60 * d - 30 * (r - b);
         end else begin
            num = (r >= g) ? 120 * d + 30 * (r - g) : 120 * d - 30 * (g - r);
         end
         h = num / d;
         if (h > 179) h = 179;
      end
      s = (s * 32'(gain)) >> hsvsb_pkg::GAIN_FRAC_BITS_DEF;
      if (s > 255) s = 255;
      sec = hsvsb_pkg::sector_type'(h / 30);
      f = h % 30;
      t = (h / 30) % 2 ? 30 - f : f;
      full_c = v;
      zero_c = (v * (255 - s)) / 255;
      ramp_c = (v * (7650 - 30 * s + s * t)) / 7650;
      case (sec)
         hsvsb_pkg::SEC_0: begin ro = full_c; go = ramp_c; bo = zero_c; end
         hsvsb_pkg::SEC_1: begin ro = ramp_c; go = full_c; bo = zero_c; end
         hsvsb_pkg::SEC_2: begin ro = zero_c; go = full_c; bo = ramp_c; end
         hsvsb_pkg::SEC_3: begin ro = zero_c; go = ramp_c; bo = full_c; end
         hsvsb_pkg::SEC_4: begin ro = ramp_c; go = zero_c; bo = full_c; end
         default:          begin ro = full_c; go = zero_c; bo = ramp_c; end
      endcase
      return {bo[7:0], go[7:0], ro[7:0]};
   endfunction

   function void note_request(logic [7:0] b, logic [7:0] g, logic [7:0] r);
      pending_pixels.push_back(boost_pixel(b, g, r));
   endfunction

   function void check_result(logic [7:0] b, logic [7:0] g, logic [7:0] r);
      logic [23:0] exp_pix;
      if (pending_pixels.size() == 0) begin
         orphan_count++;
         mismatch_count++;
         if (mismatch_count <= 10) $display("unexpected result b=%0d g=%0d r=%0d", b, g, r);
         return;
      end
      exp_pix = pending_pixels.pop_front();
      if (exp_pix !== {b, g, r}) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch: expected b=%0d g=%0d r=%0d, got b=%0d g=%0d r=%0d",
                     exp_pix[23:16], exp_pix[15:8], exp_pix[7:0], b, g, r);
      end
   endfunction
endclass

module tb;
   import hsvsb_pkg::*;

   localparam int LATENCY      = 15;
   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_ITEMS = 1500;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_blue_in, req_green_in, req_red_in;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_blue_out, rsp_green_out, rsp_red_out;
   logic       csr_valid;
   logic       csr_ready;
   logic [7:0] csr_sat_gain;

   pixel_scoreboard board;
   int          idle_cycles;
   bit          stall_random;

   hsv_saturation_boost_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_blue_in(req_blue_in), .req_green_in(req_green_in), .req_red_in(req_red_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_blue_out(rsp_blue_out), .rsp_green_out(rsp_green_out),
      .rsp_red_out(rsp_red_out),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_sat_gain(csr_sat_gain)
   );

   always begin
      clock = 1'b1; #2;
      clock = 1'b0; #2;
   end

   initial begin
      board        = new();
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_blue_in  = '0;
      req_green_in = '0;
      req_red_in   = '0;
      rsp_stall    = 1'b0;
      csr_valid    = 1'b0;
      csr_sat_gain = '0;
      stall_random = 1'b0;
   end

   // result side: draw a stall length per result, sample at the edge
   initial begin : result_side
      int gap;
      @(posedge clock);
      forever begin
         gap = stall_random ? $urandom_range(0, 19) : 0;
         if (gap > 0 && $urandom_range(0, 3) == 0) gap = 0;
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         board.check_result(rsp_blue_out, rsp_green_out, rsp_red_out);
      end
   end

   // watchdog on cycles without any accepted request, result or gain write
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
         $display("** hsv_saturation_boost_unit: FAILED **");
         $finish;
      end
   end

   task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 19) : 0;
      if (gaps && $urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_blue_in  <= b;
      req_green_in <= g;
      req_red_in   <= r;
      do @(posedge clock); while (req_stall);
      board.note_request(b, g, r);
   endtask

   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (board.pending_pixels.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_gain(logic [7:0] value);
      drain_pipe();
      csr_valid    <= 1'b1;
      csr_sat_gain <= value;
      do @(posedge clock); while (!csr_ready);
      board.gain = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // random pixel, biased toward grays, ties and extremes now and then
   task automatic send_random_pixel();
      logic [7:0] b, g, r;
      b = 8'($urandom); g = 8'($urandom); r = 8'($urandom);
      case ($urandom_range(0, 9))
         0: begin g = b; r = b; end
         1: g = r;
         2: b = g;
         3: begin r = 8'd255; b = 8'd0; end
         4: begin
            b = 8'($urandom_range(0, 3));
            g = 8'($urandom_range(0, 3));
            r = 8'($urandom_range(0, 3));
         end
         default: ;
      endcase
      send_pixel(b, g, r, 1'b1);
   endtask

   initial begin : stimulus
      logic [7:0] gain_set[6];
      int         sent;
      int         burst_len;
      gain_set = '{8'd0, 8'd255, 8'd16, 8'd1, 8'd40, 8'd24};
      idle_cycles = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset gain first: black, white, grays, primaries, red wrap, ties
      send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd77, 8'd77, 8'd77, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
      send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd200, 8'd10, 8'd255, 1'b0);
      send_pixel(8'd1, 8'd0, 8'd255, 1'b0);
      send_pixel(8'd0, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd0, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd255, 1'b0);
      send_pixel(8'd100, 8'd150, 8'd200, 1'b0);
      send_pixel(8'd1, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd128, 8'd64, 8'd32, 1'b0);
      write_gain(8'd0);
      send_pixel(8'd30, 8'd90, 8'd250, 1'b0);
      send_pixel(8'd250, 8'd5, 8'd60, 1'b0);
      write_gain(8'd255);
      send_pixel(8'd30, 8'd90, 8'd250, 1'b0);
      send_pixel(8'd0, 8'd128, 8'd255, 1'b0);
      send_pixel(8'd254, 8'd1, 8'd127, 1'b0);

      stall_random = 1'b1;
      foreach (gain_set[i]) begin
         write_gain((i == 4) ? 8'($urandom) : gain_set[i]);
         sent = 0;
         while (sent < RANDOM_ITEMS / 6) begin
            // keep some back-to-back stretches
            if ($urandom_range(0, 7) == 0) begin
               burst_len = $urandom_range(5, 30);
               repeat (burst_len)
                  send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
               sent += burst_len;
            end else begin
               send_random_pixel();
               sent++;
            end
         end
      end
      drain_pipe();

      if (board.mismatch_count == 0)
         $display("** hsv_saturation_boost_unit: PASSED **");
      else
         $display("** hsv_saturation_boost_unit: FAILED **");
      $finish;
   end
endmodule

`default_nettype wire
